/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty under SYNTH
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/wrs_pkg.sv */
// ---------------------------------------------------------------------------
// wrs_pkg
// shared constants, command and status types of the wake relaxation step
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wrs_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int SEG_W      = 31;
    localparam int MAXR_W     = 31;
    localparam int SUM_W      = 63;
    localparam int V_W        = DATA_W + 1;
    localparam int U_W        = FRAC_BITS + 2;
    localparam int ACC_W      = 49;
    localparam int A_W        = 34;
    localparam int B_W        = 33;
    localparam int PROD_W     = 64;
    localparam int SAT_W      = 66;
    localparam int RELAX_SH   = 30;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = FRAC_BITS + 1;
    localparam int CNT_W      = 5;
    localparam int NUM_AXES   = 3;
    localparam int CFG_IDX_W  = 3;

    localparam logic [1:0]        LAST_AXIS  = 2'd2;
    localparam logic [15:0]       RELAX_K    = 16'd55706;
    localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [MAXR_W-1:0] MAXR_MAX   = {MAXR_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROTOR_MODE   = 3'd0,
        CFG_RELAX_FACTOR = 3'd1,
        CFG_THRUST_X     = 3'd2,
        CFG_THRUST_Y     = 3'd3,
        CFG_THRUST_Z     = 3'd4
    } cfg_index_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_KMUL,
        OP_DIFF,
        OP_DOT,
        OP_CLAMP,
        OP_VROT,
        OP_VPLAIN,
        OP_PREPN,
        OP_SQ,
        OP_SQRT0,
        OP_SQRT,
        OP_DIV0,
        OP_DIV,
        OP_DIVW,
        OP_RES,
        OP_PDOT,
        OP_PROJ,
        OP_RSQ,
        OP_SUM,
        OP_NEW,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] idx;
        logic       ph;
        logic       to_d;
    } cmd_t;

    typedef struct packed {
        logic rotor_mode;
    } status_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(33'sh0_7fff_ffff);
        lo = -SAT_W'(33'sh0_8000_0000);
        if (v > hi)
        begin
            return 32'sh7fff_ffff;
        end
        else if (v < lo)
        begin
            return 32'sh8000_0000;
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

/* rtl/wrs_ctrl.sv */
// ---------------------------------------------------------------------------
// wrs_ctrl
// sequencer that steps the shared multiplier, root and divider per segment
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrs_ctrl
    import wrs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    item_kind,
    input  logic    out_ready,
    input  status_t status,
    output logic    in_ready,
    output logic    out_valid,
    output cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_KMUL,
        ST_DIFF,
        ST_DOT,
        ST_CLAMP,
        ST_VROT,
        ST_VPLAIN,
        ST_PREPN,
        ST_SQ,
        ST_SQRT0,
        ST_SQRT,
        ST_DIV0,
        ST_DIV,
        ST_DIVW,
        ST_RES,
        ST_PDOT,
        ST_PROJ,
        ST_RSQ,
        ST_SUM,
        ST_NEW,
        ST_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       idx_reg, idx_next;
    logic             ph_reg, ph_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             to_d_reg, to_d_next;
    logic             in_ready_reg, in_ready_next;
    logic             out_valid_reg, out_valid_next;
    logic             mul_step;
    logic             mul_last;
    logic             emit_fire;
    op_t              op;

    assign mul_last  = ph_reg && (idx_reg == LAST_AXIS);
    assign emit_fire = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        ph_next        = ph_reg;
        cnt_next       = cnt_reg;
        to_d_next      = to_d_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mul_step       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready_reg && item_kind)
                begin
                    state_next = ST_KMUL;
                    ph_next    = 1'b0;
                    idx_next   = 2'd0;
                end
            end
            ST_KMUL:
            begin
                if (ph_reg)
                begin
                    ph_next    = 1'b0;
                    state_next = status.rotor_mode ? ST_DIFF : ST_VPLAIN;
                end
                else
                begin
                    ph_next = 1'b1;
                end
            end
            ST_DIFF:
            begin
                state_next = ST_DOT;
            end
            ST_DOT:
            begin
                mul_step = 1'b1;
                if (mul_last)
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                state_next = ST_VROT;
            end
            ST_VROT:
            begin
                mul_step  = 1'b1;
                to_d_next = 1'b0;
                if (mul_last)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_VPLAIN:
            begin
                to_d_next  = 1'b0;
                state_next = ST_SQ;
            end
            ST_PREPN:
            begin
                to_d_next  = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                mul_step = 1'b1;
                if (mul_last)
                begin
                    state_next = ST_SQRT0;
                end
            end
            ST_SQRT0:
            begin
                cnt_next   = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    idx_next   = 2'd0;
                    state_next = ST_DIV0;
                end
            end
            ST_DIV0:
            begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DIVW;
                end
            end
            ST_DIVW:
            begin
                if (idx_reg == LAST_AXIS)
                begin
                    idx_next   = 2'd0;
                    state_next = to_d_reg ? ST_PDOT : ST_RES;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_DIV0;
                end
            end
            ST_RES:
            begin
                mul_step = 1'b1;
                if (mul_last)
                begin
                    state_next = status.rotor_mode ? ST_PREPN : ST_RSQ;
                end
            end
            ST_PDOT:
            begin
                mul_step = 1'b1;
                if (mul_last)
                begin
                    state_next = ST_PROJ;
                end
            end
            ST_PROJ:
            begin
                mul_step = 1'b1;
                if (mul_last)
                begin
                    state_next = ST_RSQ;
                end
            end
            ST_RSQ:
            begin
                mul_step = 1'b1;
                if (mul_last)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_NEW;
            end
            ST_NEW:
            begin
                mul_step = 1'b1;
                if (mul_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (mul_step)
        begin
            if (!ph_reg)
            begin
                ph_next = 1'b1;
            end
            else
            begin
                ph_next  = 1'b0;
                idx_next = mul_last ? 2'd0 : idx_reg + 2'd1;
            end
        end
        in_ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= 2'd0;
            ph_reg        <= 1'b0;
            cnt_reg       <= '0;
            to_d_reg      <= 1'b0;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            ph_reg        <= ph_next;
            cnt_reg       <= cnt_next;
            to_d_reg      <= to_d_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:   op = OP_NONE;
            ST_KMUL:   op = OP_KMUL;
            ST_DIFF:   op = OP_DIFF;
            ST_DOT:    op = OP_DOT;
            ST_CLAMP:  op = OP_CLAMP;
            ST_VROT:   op = OP_VROT;
            ST_VPLAIN: op = OP_VPLAIN;
            ST_PREPN:  op = OP_PREPN;
            ST_SQ:     op = OP_SQ;
            ST_SQRT0:  op = OP_SQRT0;
            ST_SQRT:   op = OP_SQRT;
            ST_DIV0:   op = OP_DIV0;
            ST_DIV:    op = OP_DIV;
            ST_DIVW:   op = OP_DIVW;
            ST_RES:    op = OP_RES;
            ST_PDOT:   op = OP_PDOT;
            ST_PROJ:   op = OP_PROJ;
            ST_RSQ:    op = OP_RSQ;
            ST_SUM:    op = OP_SUM;
            ST_NEW:    op = OP_NEW;
            ST_EMIT:   op = emit_fire ? OP_EMIT : OP_NONE;
            default:   op = OP_NONE;
        endcase
    end

    assign cmd.op    = op;
    assign cmd.idx   = idx_reg;
    assign cmd.ph    = ph_reg;
    assign cmd.to_d  = to_d_reg;
    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

/* rtl/wrs_dp.sv */
// ---------------------------------------------------------------------------
// wrs_dp
// datapath: config, held node, shared multiplier, root and divider units
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrs_dp
    import wrs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output status_t                  status,
    input  logic                     cfg_accept,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     in_accept,
    input  logic                     item_kind,
    input  logic                     final_segment,
    input  logic signed [DATA_W-1:0] vel_x,
    input  logic signed [DATA_W-1:0] vel_y,
    input  logic signed [DATA_W-1:0] vel_z,
    input  logic signed [DATA_W-1:0] stream_x,
    input  logic signed [DATA_W-1:0] stream_y,
    input  logic signed [DATA_W-1:0] stream_z,
    input  logic signed [DATA_W-1:0] node_x,
    input  logic signed [DATA_W-1:0] node_y,
    input  logic signed [DATA_W-1:0] node_z,
    input  logic [SEG_W-1:0]         seg_len,
    output logic signed [DATA_W-1:0] new_x,
    output logic signed [DATA_W-1:0] new_y,
    output logic signed [DATA_W-1:0] new_z,
    output logic [MAXR_W-1:0]        res_max,
    output logic [SUM_W-1:0]         res_sum_sq,
    output logic                     last
);

    typedef enum logic [1:0] {
        SH_NONE,
        SH_FRAC,
        SH_RELAX
    } shift_t;

    logic signed [DATA_W-1:0] vel_in [NUM_AXES];
    logic signed [DATA_W-1:0] str_in [NUM_AXES];
    logic signed [DATA_W-1:0] node_in [NUM_AXES];

    logic                     rotor_reg;
    logic [15:0]              relax_reg;
    logic signed [DATA_W-1:0] th_reg [NUM_AXES];
    logic signed [DATA_W-1:0] prev_reg [NUM_AXES];
    logic [MAXR_W-1:0]        max_reg;
    logic [SUM_W-1:0]         sum_reg;

    logic signed [DATA_W-1:0] vel_reg [NUM_AXES];
    logic signed [DATA_W-1:0] str_reg [NUM_AXES];
    logic signed [DATA_W-1:0] node_reg [NUM_AXES];
    logic signed [DATA_W-1:0] diff_reg [NUM_AXES];
    logic signed [DATA_W-1:0] r_reg [NUM_AXES];
    logic signed [V_W-1:0]    v_reg [NUM_AXES];
    logic signed [U_W-1:0]    u_reg [NUM_AXES];
    logic signed [U_W-1:0]    d_reg [NUM_AXES];
    logic [SEG_W-1:0]         seg_reg;
    logic                     last_in_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [DATA_W-1:0] dotv_reg;
    logic [PROD_W-1:0]        s_reg;
    logic [PROD_W-1:0]        sq_reg;
    logic [DATA_W-1:0]        k_reg;
    logic [PROD_W-1:0]        sx_reg;
    logic [PROD_W-1:0]        sr_reg;
    logic [PROD_W-1:0]        sbit_reg;
    logic [DATA_W-1:0]        drem_reg;
    logic [DIV_STEPS-1:0]     dnum_reg;
    logic [DIV_STEPS-1:0]     dq_reg;
    logic                     dneg_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic                     neg_reg;
    shift_t                   sh_reg;

    logic signed [DATA_W-1:0] new_reg [NUM_AXES];
    logic [MAXR_W-1:0]        res_max_reg;
    logic [SUM_W-1:0]         res_sum_reg;
    logic                     last_reg;

    logic signed [A_W-1:0]    a_op;
    logic signed [B_W-1:0]    b_op;
    shift_t                   sh_sel;
    logic [A_W-1:0]           a_abs;
    logic [B_W-1:0]           b_abs;
    logic [A_W+B_W-3:0]       prod_full;
    logic [PROD_W-1:0]        q_shift;
    logic signed [PROD_W:0]   res;
    logic [PROD_W-1:0]        sq_try;
    logic [DATA_W:0]          div_try;
    logic [DATA_W-1:0]        root;
    logic signed [V_W-1:0]    v_sel;
    logic [V_W-1:0]           v_abs;
    logic signed [V_W-1:0]    r_ext;
    logic [V_W-1:0]           r_abs;
    logic [MAXR_W-1:0]        r_clip;
    logic [SUM_W+1:0]         sum_total;
    logic [SUM_W-1:0]         sum_new;
    logic [U_W-1:0]           q_ext;
    logic signed [U_W-1:0]    unit_val;
    logic [1:0]               i;

    assign vel_in  = '{vel_x, vel_y, vel_z};
    assign str_in  = '{stream_x, stream_y, stream_z};
    assign node_in = '{node_x, node_y, node_z};
    assign i       = cmd.idx;

    // multiplier operand select
    always_comb
    begin
        a_op   = '0;
        b_op   = '0;
        sh_sel = SH_NONE;
        unique case (cmd.op)
            OP_KMUL:
            begin
                a_op = A_W'($signed({1'b0, relax_reg}));
                b_op = B_W'($signed({1'b0, RELAX_K}));
            end
            OP_DOT:
            begin
                a_op   = A_W'(th_reg[i]);
                b_op   = B_W'(diff_reg[i]);
                sh_sel = SH_FRAC;
            end
            OP_VROT:
            begin
                a_op   = A_W'(dotv_reg);
                b_op   = B_W'(th_reg[i]);
                sh_sel = SH_FRAC;
            end
            OP_SQ:
            begin
                a_op = A_W'(v_reg[i]);
                b_op = B_W'(v_reg[i]);
            end
            OP_RES:
            begin
                a_op   = A_W'(u_reg[i]);
                b_op   = B_W'($signed({1'b0, seg_reg}));
                sh_sel = SH_FRAC;
            end
            OP_PDOT:
            begin
                a_op   = A_W'(r_reg[i]);
                b_op   = B_W'(d_reg[i]);
                sh_sel = SH_FRAC;
            end
            OP_PROJ:
            begin
                a_op   = acc_reg[A_W-1:0];
                b_op   = B_W'(d_reg[i]);
                sh_sel = SH_FRAC;
            end
            OP_RSQ:
            begin
                a_op = A_W'(r_reg[i]);
                b_op = B_W'(r_reg[i]);
            end
            OP_NEW:
            begin
                a_op   = A_W'(r_reg[i]);
                b_op   = $signed({1'b0, k_reg});
                sh_sel = SH_RELAX;
            end
            default:
            begin
                sh_sel = SH_NONE;
            end
        endcase
    end

    assign a_abs     = a_op[A_W-1] ? A_W'(-a_op) : A_W'(a_op);
    assign b_abs     = b_op[B_W-1] ? B_W'(-b_op) : B_W'(b_op);
    assign prod_full = a_abs[A_W-2:0] * b_abs[B_W-2:0];

    always_comb
    begin
        case (sh_reg)
            SH_FRAC:  q_shift = prod_reg >> FRAC_BITS;
            SH_RELAX: q_shift = prod_reg >> RELAX_SH;
            default:  q_shift = prod_reg;
        endcase
    end

    assign res = neg_reg ? -$signed({1'b0, q_shift}) : $signed({1'b0, q_shift});

    assign sq_try  = sr_reg + sbit_reg;
    assign root    = sr_reg[DATA_W-1:0];
    assign div_try = {drem_reg, dnum_reg[DIV_STEPS-1]};

    assign v_sel = v_reg[i];
    assign v_abs = v_sel[V_W-1] ? V_W'(-v_sel) : V_W'(v_sel);

    assign r_ext  = V_W'(r_reg[i]);
    assign r_abs  = r_ext[V_W-1] ? V_W'(-r_ext) : V_W'(r_ext);
    assign r_clip = (r_abs > V_W'(MAXR_MAX)) ? MAXR_MAX : r_abs[MAXR_W-1:0];

    assign sum_total = (SUM_W+2)'(sum_reg) + (SUM_W+2)'(sq_reg);
    assign sum_new   = (sum_total > (SUM_W+2)'(SUM_MAX)) ? SUM_MAX : sum_total[SUM_W-1:0];

    assign q_ext    = U_W'(dq_reg);
    assign unit_val = (root == '0) ? '0 : (dneg_reg ? -$signed(q_ext) : $signed(q_ext));

    // config, held node and running statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotor_reg <= 1'b0;
            relax_reg <= 16'd16384;
            th_reg    <= '{-32'sd65536, 32'sd0, 32'sd0};
            prev_reg  <= '{32'sd0, 32'sd0, 32'sd0};
            max_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            if (cfg_accept)
            begin
                case (cfg_index)
                    CFG_ROTOR_MODE:   rotor_reg <= cfg_data[0];
                    CFG_RELAX_FACTOR: relax_reg <= cfg_data[15:0];
                    CFG_THRUST_X:     th_reg[0] <= cfg_data;
                    CFG_THRUST_Y:     th_reg[1] <= cfg_data;
                    CFG_THRUST_Z:     th_reg[2] <= cfg_data;
                    default:          rotor_reg <= rotor_reg;
                endcase
            end
            if (in_accept && !item_kind)
            begin
                prev_reg <= node_in;
                max_reg  <= '0;
                sum_reg  <= '0;
            end
            if (cmd.op == OP_RSQ && cmd.ph && r_clip > max_reg)
            begin
                max_reg <= r_clip;
            end
            if (cmd.op == OP_SUM)
            begin
                sum_reg <= sum_new;
            end
            if (cmd.op == OP_NEW && cmd.ph)
            begin
                prev_reg[i] <= sat32(SAT_W'(node_reg[i]) - SAT_W'(res));
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[PROD_W-1:0];
        neg_reg  <= a_op[A_W-1] ^ b_op[B_W-1];
        sh_reg   <= sh_sel;
        if (in_accept)
        begin
            vel_reg     <= vel_in;
            str_reg     <= str_in;
            node_reg    <= node_in;
            seg_reg     <= seg_len;
            last_in_reg <= final_segment;
        end
        unique case (cmd.op)
            OP_KMUL:
            begin
                if (cmd.ph)
                begin
                    k_reg <= res[DATA_W-1:0];
                end
            end
            OP_DIFF:
            begin
                for (int k = 0; k < NUM_AXES; k++)
                begin
                    diff_reg[k] <= sat32(SAT_W'(vel_reg[k]) - SAT_W'(str_reg[k]));
                end
                acc_reg <= '0;
                sq_reg  <= '0;
            end
            OP_DOT, OP_PDOT:
            begin
                if (cmd.ph)
                begin
                    acc_reg <= acc_reg + res[ACC_W-1:0];
                end
            end
            OP_CLAMP:
            begin
                dotv_reg <= (sat32(SAT_W'(acc_reg)) > 0) ? '0 : sat32(SAT_W'(acc_reg));
                s_reg    <= '0;
            end
            OP_VROT:
            begin
                if (cmd.ph)
                begin
                    v_reg[i] <= V_W'(sat32(SAT_W'(str_reg[i]) + SAT_W'(res)));
                end
            end
            OP_VPLAIN:
            begin
                for (int k = 0; k < NUM_AXES; k++)
                begin
                    v_reg[k] <= V_W'(vel_reg[k]);
                end
                s_reg  <= '0;
                sq_reg <= '0;
            end
            OP_PREPN:
            begin
                for (int k = 0; k < NUM_AXES; k++)
                begin
                    v_reg[k] <= -V_W'(th_reg[k]);
                end
                s_reg   <= '0;
                acc_reg <= '0;
            end
            OP_SQ:
            begin
                if (cmd.ph)
                begin
                    s_reg <= s_reg + res[PROD_W-1:0];
                end
            end
            OP_SQRT0:
            begin
                sx_reg   <= s_reg;
                sr_reg   <= '0;
                sbit_reg <= {2'b01, {(PROD_W-2){1'b0}}};
            end
            OP_SQRT:
            begin
                if (sx_reg >= sq_try)
                begin
                    sx_reg <= sx_reg - sq_try;
                    sr_reg <= (sr_reg >> 1) + sbit_reg;
                end
                else
                begin
                    sr_reg <= sr_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            OP_DIV0:
            begin
                drem_reg <= DATA_W'(v_abs >> 1);
                dnum_reg <= {v_abs[0], {FRAC_BITS{1'b0}}};
                dq_reg   <= '0;
                dneg_reg <= v_sel[V_W-1];
            end
            OP_DIV:
            begin
                if (div_try >= {1'b0, root})
                begin
                    drem_reg <= DATA_W'(div_try - {1'b0, root});
                    dq_reg   <= {dq_reg[DIV_STEPS-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= div_try[DATA_W-1:0];
                    dq_reg   <= {dq_reg[DIV_STEPS-2:0], 1'b0};
                end
                dnum_reg <= dnum_reg << 1;
            end
            OP_DIVW:
            begin
                if (cmd.to_d)
                begin
                    d_reg[i] <= unit_val;
                end
                else
                begin
                    u_reg[i] <= unit_val;
                end
            end
            OP_RES:
            begin
                if (cmd.ph)
                begin
                    r_reg[i] <= sat32(SAT_W'(node_reg[i]) - SAT_W'(prev_reg[i]) - SAT_W'(res));
                end
            end
            OP_PROJ:
            begin
                if (cmd.ph)
                begin
                    r_reg[i] <= sat32(SAT_W'(res));
                end
            end
            OP_RSQ:
            begin
                if (cmd.ph)
                begin
                    sq_reg <= sq_reg + res[PROD_W-1:0];
                end
            end
            OP_EMIT:
            begin
                new_reg     <= prev_reg;
                res_max_reg <= max_reg;
                res_sum_reg <= sum_reg;
                last_reg    <= last_in_reg;
            end
            default:
            begin
                last_reg <= last_reg;
            end
        endcase
    end

    assign status.rotor_mode = rotor_reg;
    assign new_x             = new_reg[0];
    assign new_y             = new_reg[1];
    assign new_z             = new_reg[2];
    assign res_max           = res_max_reg;
    assign res_sum_sq        = res_sum_reg;
    assign last              = last_reg;

endmodule

/* rtl/wake_relaxation_step_core.sv */
// ---------------------------------------------------------------------------
// wake_relaxation_step_core
// relaxes one wake line node per segment word, with residual statistics
// ---------------------------------------------------------------------------
// channel  signals                      word
// in       in_valid / in_ready          anchor or segment, node, velocities
// out      out_valid / out_ready        relaxed node, residual max and sum
// cfg      cfg_valid / cfg_ready        cfg_index, cfg_data
//
// a segment is paced by the 32-step square root and the 17-step divider per unit
// component, and rotor mode forms a second unit vector, so its segments take longer
// an anchor is taken without leaving idle and gives no output word
// the result sits in an output register; the next word is taken meanwhile
// reset is asynchronous active low and restores default config and zero node
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wake_relaxation_step_core
    import wrs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     item_kind,
    input  logic                     final_segment,
    input  logic signed [DATA_W-1:0] vel_x,
    input  logic signed [DATA_W-1:0] vel_y,
    input  logic signed [DATA_W-1:0] vel_z,
    input  logic signed [DATA_W-1:0] stream_x,
    input  logic signed [DATA_W-1:0] stream_y,
    input  logic signed [DATA_W-1:0] stream_z,
    input  logic signed [DATA_W-1:0] node_x,
    input  logic signed [DATA_W-1:0] node_y,
    input  logic signed [DATA_W-1:0] node_z,
    input  logic [SEG_W-1:0]         seg_len,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] new_x,
    output logic signed [DATA_W-1:0] new_y,
    output logic signed [DATA_W-1:0] new_z,
    output logic [MAXR_W-1:0]        res_max,
    output logic [SUM_W-1:0]         res_sum_sq,
    output logic                     last
);

    cmd_t    cmd;
    status_t status;
    logic    in_accept;
    logic    cfg_accept;
    logic    mul_op;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign in_accept  = in_valid && in_ready;
    assign mul_op     = cmd.op inside {OP_KMUL, OP_DOT, OP_VROT, OP_SQ, OP_RES,
                                       OP_PDOT, OP_PROJ, OP_RSQ, OP_NEW};

    wrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .item_kind (item_kind),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    wrs_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_accept    (cfg_accept),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_accept     (in_accept),
        .item_kind     (item_kind),
        .final_segment (final_segment),
        .vel_x         (vel_x),
        .vel_y         (vel_y),
        .vel_z         (vel_z),
        .stream_x      (stream_x),
        .stream_y      (stream_y),
        .stream_z      (stream_z),
        .node_x        (node_x),
        .node_y        (node_y),
        .node_z        (node_z),
        .seg_len       (seg_len),
        .new_x         (new_x),
        .new_y         (new_y),
        .new_z         (new_z),
        .res_max       (res_max),
        .res_sum_sq    (res_sum_sq),
        .last          (last)
    );

    // no work while the input side is open
    `ASSERT_IMPLIES(a_ready_quiet, clk, rst_n, in_ready, cmd.op == OP_NONE)
    // a pending word is never overwritten
    `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, out_valid && !out_ready, cmd.op != OP_EMIT)
    // an emitted word shows up at the port
    `ASSERT_NEXT(a_emit_shown, clk, rst_n, cmd.op == OP_EMIT, out_valid)
    // second phase only on multiplier steps
    `ASSERT_IMPLIES(a_phase_mul, clk, rst_n, cmd.ph, mul_op)

endmodule

/* bench/wake_relaxation_step_core_tb.sv */
// ---------------------------------------------------------------------------
// wake_relaxation_step_core_tb
// checks relaxed nodes and residual statistics of the wake relaxation core
// against a behavioral predictor, over directed corners and random wake lines
// in plain and rotor mode, with bursty input, output stalls and one long hold
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wake_relaxation_step_core_tb;
    import wrs_pkg::*;

    localparam logic              KIND_ANCHOR  = 1'b0;
    localparam logic              KIND_SEGMENT = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;
    localparam int                IDLE_LIMIT   = 15000;
    localparam int                DRAIN_CYCLES = 300;
    localparam logic [63:0]       SQ_CEIL      = 64'h7fff_ffff_ffff_ffff;
    localparam longint            K_RELAX      = 55706;

    typedef struct {
        logic        kind;
        logic        fin;
        logic signed [31:0] vel [3];
        logic signed [31:0] str [3];
        logic signed [31:0] node [3];
        logic [30:0] seg;
    } seg_word_t;

    typedef struct {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic [30:0] rmax;
        logic [62:0] ssq;
        logic        lst;
    } node_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic item_kind = 1'b0;
    logic final_segment = 1'b0;
    logic signed [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
    logic signed [31:0] stream_x = '0, stream_y = '0, stream_z = '0;
    logic signed [31:0] node_x = '0, node_y = '0, node_z = '0;
    logic [30:0] seg_len = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] new_x, new_y, new_z;
    logic [30:0] res_max;
    logic [62:0] res_sum_sq;
    logic last;

    wake_relaxation_step_core u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state and configuration
    logic        rotor_on = 1'b0;
    logic [15:0] relax_q = 16'd16384;
    longint      thrust [3] = '{-65536, 0, 0};
    longint      prev_node [3] = '{0, 0, 0};
    logic [30:0] peak_res = '0;
    logic [63:0] sq_total = '0;

    seg_word_t  pending_words [$];
    node_word_t expected_nodes [$];
    int         err_cnt = 0;
    int         nodes_seen = 0;
    bit         calm = 1'b0;
    int         idle_cycles = 0;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic [63:0] absval(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint mul_shift(input longint a, input longint b, input int sh);
        logic [63:0] q;
        q = (absval(a) * absval(b)) >> sh;
        return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic unit_vec(input longint v [3], output longint u [3]);
        logic [63:0] s;
        logic [63:0] m;
        logic [63:0] q;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            s = s + absval(v[i]) * absval(v[i]);
        end
        m = int_sqrt(s);
        for (int i = 0; i < 3; i++)
        begin
            if (m == 0)
            begin
                u[i] = 0;
            end
            else
            begin
                q = (absval(v[i]) << FRAC_BITS) / m;
                u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
            end
        end
    endtask

    task automatic relax_node(input seg_word_t w);
        longint v [3], u [3], r [3], d [3], nt [3], nd [3];
        longint dot;
        longint relax;
        logic [63:0] sq;
        logic [63:0] a;
        node_word_t e;
        if (w.kind == KIND_ANCHOR)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prev_node[i] = longint'(w.node[i]);
            end
            peak_res = '0;
            sq_total = '0;
            return;
        end
        if (rotor_on)
        begin
            dot = 0;
            for (int i = 0; i < 3; i++)
            begin
                dot += mul_shift(thrust[i],
                                 clamp32(longint'(w.vel[i]) - longint'(w.str[i])), FRAC_BITS);
            end
            dot = clamp32(dot);
            if (dot > 0)
            begin
                dot = 0;
            end
            for (int i = 0; i < 3; i++)
            begin
                v[i] = clamp32(longint'(w.str[i]) + mul_shift(dot, thrust[i], FRAC_BITS));
            end
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                v[i] = longint'(w.vel[i]);
            end
        end
        unit_vec(v, u);
        for (int i = 0; i < 3; i++)
        begin
            r[i] = clamp32(longint'(w.node[i]) - prev_node[i]
                           - mul_shift(u[i], longint'({33'd0, w.seg}), FRAC_BITS));
        end
        if (rotor_on)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nt[i] = -thrust[i];
            end
            unit_vec(nt, d);
            dot = 0;
            for (int i = 0; i < 3; i++)
            begin
                dot += mul_shift(r[i], d[i], FRAC_BITS);
            end
            for (int i = 0; i < 3; i++)
            begin
                r[i] = clamp32(mul_shift(dot, d[i], FRAC_BITS));
            end
        end
        sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            a = absval(r[i]);
            sq = sq + a * a;
            if (a > 64'h7fff_ffff)
            begin
                a = 64'h7fff_ffff;
            end
            if (a > {33'd0, peak_res})
            begin
                peak_res = a[30:0];
            end
        end
        if (sq_total > SQ_CEIL)
        begin
            sq_total = SQ_CEIL;
        end
        if (sq > SQ_CEIL - sq_total)
        begin
            sq_total = SQ_CEIL;
        end
        else
        begin
            sq_total = sq_total + sq;
        end
        relax = longint'({48'd0, relax_q}) * K_RELAX;
        for (int i = 0; i < 3; i++)
        begin
            nd[i] = clamp32(longint'(w.node[i]) - mul_shift(r[i], relax, RELAX_SH));
            prev_node[i] = nd[i];
        end
        e.nx = nd[0][31:0];
        e.ny = nd[1][31:0];
        e.nz = nd[2][31:0];
        e.rmax = peak_res;
        e.ssq = sq_total[62:0];
        e.lst = w.fin;
        expected_nodes.push_back(e);
    endtask

    // input driver
    seg_word_t cur_word;
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk)
    begin
        logic fire;
        logic nv;
        if (rst_n)
        begin
            fire = in_valid && in_ready;
            if (fire)
            begin
                relax_node(cur_word);
            end
            nv = in_valid && !fire;
            if (!nv)
            begin
                if (gap_left > 0 && !calm)
                begin
                    gap_left--;
                end
                else if (pending_words.size() > 0)
                begin
                    cur_word = pending_words.pop_front();
                    item_kind <= cur_word.kind;
                    final_segment <= cur_word.fin;
                    vel_x <= cur_word.vel[0];
                    vel_y <= cur_word.vel[1];
                    vel_z <= cur_word.vel[2];
                    stream_x <= cur_word.str[0];
                    stream_y <= cur_word.str[1];
                    stream_z <= cur_word.str[2];
                    node_x <= cur_word.node[0];
                    node_y <= cur_word.node[1];
                    node_z <= cur_word.node[2];
                    seg_len <= cur_word.seg;
                    nv = 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = $urandom_range(1, 6);
                    end
                end
            end
            in_valid <= nv;
        end
    end

    // output monitor and stall pattern
    int hold_left = 0;
    bit hold_done = 1'b0;
    int stall_mode = 0;
    int rx_cycle = 0;

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        node_word_t e;
        logic rdy;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                nodes_seen++;
                if (expected_nodes.size() == 0)
                begin
                    $error("output word with no expectation pending");
                    err_cnt++;
                end
                else
                begin
                    e = expected_nodes.pop_front();
                    check_field("new_x", 64'(e.nx), 64'(new_x));
                    check_field("new_y", 64'(e.ny), 64'(new_y));
                    check_field("new_z", 64'(e.nz), 64'(new_z));
                    check_field("res_max", 64'(e.rmax), 64'(res_max));
                    check_field("res_sum_sq", 64'(e.ssq), 64'(res_sum_sq));
                    check_field("last", 64'(e.lst), 64'(last));
                end
            end
            rx_cycle++;
            if (rx_cycle % 256 == 0)
            begin
                stall_mode = $urandom_range(0, 2);
            end
            if (!hold_done && nodes_seen == 40)
            begin
                hold_done = 1'b1;
                hold_left = 2500;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (calm || stall_mode == 0)
            begin
                rdy = 1'b1;
            end
            else if (stall_mode == 1)
            begin
                rdy = 1'($urandom_range(0, 1));
            end
            else
            begin
                rdy = (rx_cycle % 4) != 3;
            end
            out_ready <= rdy;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // stimulus
    function automatic logic signed [31:0] pick_val();
        case ($urandom_range(0, 6))
            0, 1:    return $urandom;
            2:       return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
            3:       return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            4:       return $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
            5:       return 32'sh0;
            default: return $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic logic [30:0] pick_len();
        case ($urandom_range(0, 5))
            0:       return 31'($urandom);
            1:       return 31'h7fff_ffff;
            2:       return '0;
            default: return 31'($urandom_range(0, 32'h0008_0000));
        endcase
    endfunction

    task automatic push_word(input logic kind, input logic fin,
                             input logic signed [31:0] vx, input logic signed [31:0] vy,
                             input logic signed [31:0] vz, input logic signed [31:0] sx,
                             input logic signed [31:0] sy, input logic signed [31:0] sz,
                             input logic signed [31:0] nx, input logic signed [31:0] ny,
                             input logic signed [31:0] nz, input logic [30:0] len);
        seg_word_t w;
        w.kind = kind;
        w.fin = fin;
        w.vel = '{vx, vy, vz};
        w.str = '{sx, sy, sz};
        w.node = '{nx, ny, nz};
        w.seg = len;
        pending_words.push_back(w);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ROTOR_MODE:   rotor_on = data[0];
            CFG_RELAX_FACTOR: relax_q = data[15:0];
            CFG_THRUST_X:     thrust[0] = longint'($signed(data));
            CFG_THRUST_Y:     thrust[1] = longint'($signed(data));
            CFG_THRUST_Z:     thrust[2] = longint'($signed(data));
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || in_valid || expected_nodes.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // wake lines: anchor, then segments stepping near the previous node, mixed with random words
    task automatic push_lines(input int n_words);
        logic signed [31:0] pos [3];
        int left;
        int seg_cnt;
        left = n_words;
        while (left > 0)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                push_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_val(),
                          pick_val(), pick_val(), pick_val(), pick_val(), pick_val(),
                          pick_val(), pick_val(), pick_val(), pick_len());
                left--;
                continue;
            end
            for (int i = 0; i < 3; i++)
            begin
                pos[i] = $urandom_range(0, 3) == 0 ? pick_val()
                         : $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            end
            push_word(KIND_ANCHOR, 1'($urandom_range(0, 1)), pick_val(), pick_val(),
                      pick_val(), pick_val(), pick_val(), pick_val(), pos[0], pos[1], pos[2],
                      pick_len());
            left--;
            seg_cnt = $urandom_range(2, 16);
            for (int s = 0; s < seg_cnt && left > 0; s++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pos[i] = $urandom_range(0, 7) == 0 ? pick_val()
                             : pos[i] + ($signed($urandom_range(0, 32'h0004_0000))
                                         - 32'sh0002_0000);
                end
                push_word(KIND_SEGMENT, (s == seg_cnt - 1) || (left == 1),
                          pick_val(), pick_val(), pick_val(), pick_val(), pick_val(),
                          pick_val(), pos[0], pos[1], pos[2], pick_len());
                left--;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners at reset configuration
        calm = 1'b1;
        push_word(KIND_SEGMENT, 1'b0, 32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
                  32'sh0002_0000, 32'sh0001_0000, 32'sh0, 31'h0001_0000);
        push_word(KIND_ANCHOR, 1'b1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, 32'sh0, 32'sh0,
                  32'sh0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 31'h7fff_ffff);
        push_word(KIND_SEGMENT, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh1234_5678, 32'sh0, 32'sh0,
                  32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h7fff_ffff);
        push_word(KIND_SEGMENT, 1'b0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                  32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff);
        push_word(KIND_SEGMENT, 1'b0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                  32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 31'h0);
        push_word(KIND_ANCHOR, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
                  32'sh7fff_ffff, 32'sh0, 32'sh8000_0000, 31'h0);
        push_word(KIND_SEGMENT, 1'b0, 32'sh0, 32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
                  32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 31'h0);
        push_word(KIND_SEGMENT, 1'b1, 32'sh0000_8000, 32'shffff_8000, 32'sh0001_0000,
                  32'sh0, 32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0, 32'sh0, 31'h0001_8000);
        wait_idle();

        // rotor mode, thrust along -x, all registers written
        write_reg(CFG_ROTOR_MODE, 32'd1);
        write_reg(CFG_RELAX_FACTOR, 32'd16384);
        write_reg(CFG_THRUST_X, 32'hffff_0000);
        write_reg(CFG_THRUST_Y, 32'h0000_0000);
        write_reg(CFG_THRUST_Z, 32'h0000_0000);
        write_reg(CFG_SPARE, $urandom);
        push_word(KIND_ANCHOR, 1'b0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
                  32'sh0, 32'sh0, 32'sh0, 31'h0);
        // dot positive clamps to zero, then dot negative rebuilds the velocity
        push_word(KIND_SEGMENT, 1'b0, 32'shfffe_0000, 32'sh0, 32'sh0, 32'sh0001_0000,
                  32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0, 31'h0001_0000);
        push_word(KIND_SEGMENT, 1'b0, 32'sh0003_0000, 32'sh0001_0000, 32'sh0, 32'sh0,
                  32'sh0, 32'sh0, 32'sh0003_0000, 32'sh0, 32'sh0001_0000, 31'h0002_0000);
        push_word(KIND_SEGMENT, 1'b1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                  32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh7fff_ffff, 32'sh8000_0000, 31'h7fff_ffff);
        calm = 1'b0;
        push_lines(220);
        wait_idle();

        // plain mode, no relaxation
        write_reg(CFG_ROTOR_MODE, 32'd0);
        write_reg(CFG_RELAX_FACTOR, 32'd0);
        push_lines(200);
        wait_idle();

        // plain mode, largest relaxation
        write_reg(CFG_RELAX_FACTOR, 32'd65535);
        push_lines(220);
        wait_idle();

        // rotor mode, zero thrust
        write_reg(CFG_ROTOR_MODE, 32'd1);
        write_reg(CFG_THRUST_X, 32'h0);
        push_lines(80);
        wait_idle();

        // rotor mode, extreme thrust
        write_reg(CFG_THRUST_X, 32'h8000_0000);
        write_reg(CFG_THRUST_Y, 32'h7fff_ffff);
        write_reg(CFG_THRUST_Z, 32'h8000_0000);
        push_lines(120);
        wait_idle();

        // random settings
        for (int p = 0; p < 4; p++)
        begin
            write_reg(CFG_ROTOR_MODE, $urandom);
            write_reg(CFG_RELAX_FACTOR, $urandom);
            write_reg(CFG_THRUST_X, $urandom_range(0, 1) ? $urandom
                      : 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000));
            write_reg(CFG_THRUST_Y, $urandom_range(0, 1) ? $urandom
                      : 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000));
            write_reg(CFG_THRUST_Z, $urandom_range(0, 1) ? $urandom
                      : 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000));
            calm = (p == 1);
            push_lines(110);
            wait_idle();
        end

        if (err_cnt == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
